// ----- hdl/gcs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gcs_pkg
// Shared types and constants for the GPIO / chip-select register block.
// ----------------------------------------------------------------------------
package gcs_pkg;

  // Access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Dense register numbers
  localparam logic [4:0] REG_PA_CTRL     = 5'd0;
  localparam logic [4:0] REG_PA_DIR      = 5'd1;
  localparam logic [4:0] REG_PA_DATA     = 5'd2;
  localparam logic [4:0] REG_PB_CTRL     = 5'd3;
  localparam logic [4:0] REG_PB_DIR      = 5'd4;
  localparam logic [4:0] REG_PB_DATA     = 5'd5;
  localparam logic [4:0] REG_IRQ_ONE     = 5'd6;
  localparam logic [4:0] REG_IRQ_TWO     = 5'd7;
  localparam logic [4:0] REG_PERIPH_IRQ  = 5'd8;
  localparam logic [4:0] REG_PERIPH_VEC  = 5'd9;
  localparam logic [4:0] REG_SELECT_FIRST = 5'd10;

  // Configuration register numbers
  localparam int         CFG_IDX_W     = 1;
  localparam logic [0:0] CFG_PA_ATTACH = 1'd0;
  localparam logic [0:0] CFG_PB_ATTACH = 1'd1;

  // Reset and fixed read values
  localparam logic [15:0] SELECT_BASE_RESET   = 16'hC001;
  localparam logic [15:0] SELECT_OPTION_RESET = 16'hDFFD;
  localparam logic [15:0] PENDING_BITS        = 16'h8888;
  localparam logic [15:0] UNREADABLE_VALUE    = 16'h00FF;
  localparam logic [15:0] DETACHED_VALUE      = 16'hFFFF;

  // One bus access
  typedef struct packed {
    logic        opcode;
    logic [4:0]  reg_index;
    logic [15:0] write_data;
    logic [15:0] write_mask;
    logic [7:0]  port_a_pins;
    logic [15:0] port_b_pins;
  } access_t;

  // One access result
  typedef struct packed {
    logic [15:0] read_data;
    logic [7:0]  port_a_drive;
    logic        port_a_drive_valid;
    logic [15:0] port_b_drive;
    logic [15:0] port_b_drive_mask;
    logic        port_b_drive_valid;
  } result_t;

  // Masked merge of write data into a register
  function automatic logic [15:0] merge(input logic [15:0] old_val,
                                        input logic [15:0] data,
                                        input logic [15:0] mask);
    return (old_val & ~mask) | (data & mask);
  endfunction

endpackage
`default_nettype wire

// ----- hdl/gcs_in_reg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gcs_in_reg
// Input register: captures one access per transfer and holds it until the
// register file consumes it.
// ----------------------------------------------------------------------------
module gcs_in_reg
  import gcs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire access_t in_access,
  input  wire logic    take,
  output logic         held_valid,
  output access_t      held_access
);

  // Free when empty or when the held access leaves this cycle
  assign in_ready = !held_valid || take;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_access <= in_access;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/gcs_regfile.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gcs_regfile
// Register file: port, interrupt, vector and chip-select registers, the
// attach configuration, and the decode that turns one access into a result.
// ----------------------------------------------------------------------------
module gcs_regfile
  import gcs_pkg::*;
#(
  parameter int NUM_CHIP_SELECTS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic                 cfg_data,
  input  wire logic                 go,
  input  wire access_t              acc,
  output result_t                   res
);

  localparam int         SEL_W   = (NUM_CHIP_SELECTS > 1) ? $clog2(NUM_CHIP_SELECTS) : 1;
  localparam logic [4:0] SEL_END = 5'(REG_SELECT_FIRST + 2 * NUM_CHIP_SELECTS);

  logic        port_a_attached;
  logic        port_b_attached;
  logic [15:0] port_a_control;
  logic [15:0] port_a_direction;
  logic [15:0] port_a_latch;
  logic [15:0] port_b_control;
  logic [15:0] port_b_direction;
  logic [15:0] port_b_latch;
  logic [15:0] irq_control_one;
  logic [15:0] irq_control_two;
  logic [15:0] periph_irq_control;
  logic [15:0] periph_vector;
  logic [15:0] select_base   [NUM_CHIP_SELECTS];
  logic [15:0] select_option [NUM_CHIP_SELECTS];

  logic             is_write;
  logic [4:0]       sel_offset;
  logic             is_select;
  logic             is_option;
  logic [SEL_W-1:0] sel_idx;
  logic [7:0]       pa_view;
  logic [15:0]      pb_view;
  logic [15:0]      wr_merged;

  // Decode
  assign is_write   = (acc.opcode == OP_WRITE);
  assign sel_offset = acc.reg_index - REG_SELECT_FIRST;
  assign is_select  = (acc.reg_index >= REG_SELECT_FIRST) && (acc.reg_index < SEL_END);
  assign is_option  = sel_offset[0];
  assign sel_idx    = is_select ? sel_offset[SEL_W:1] : '0;

  // Port views: pins on input bits, latch on output bits, dedicated bits cleared
  assign pa_view = ((acc.port_a_pins & ~port_a_direction[7:0]) |
                    (port_a_latch[7:0] & port_a_direction[7:0])) & ~port_a_control[7:0];
  assign pb_view = ((acc.port_b_pins & ~port_b_direction) |
                    (port_b_latch & port_b_direction)) & ~port_b_control;

  // Result of the access
  always_comb begin
    res = '0;
    if (!is_write) begin
      priority if (acc.reg_index == REG_PA_DATA) begin
        res.read_data = port_a_attached ? {8'h00, pa_view} : DETACHED_VALUE;
      end else if (acc.reg_index == REG_PB_DATA) begin
        res.read_data = port_b_attached ? pb_view : DETACHED_VALUE;
      end else if (acc.reg_index == REG_IRQ_TWO) begin
        res.read_data = irq_control_two;
      end else if (is_select) begin
        res.read_data = is_option ? select_option[sel_idx] : select_base[sel_idx];
      end else begin
        res.read_data = UNREADABLE_VALUE;
      end
    end else begin
      if (acc.reg_index == REG_PA_DATA && port_a_attached) begin
        res.port_a_drive       = acc.write_data[7:0];
        res.port_a_drive_valid = 1'b1;
      end
      if (acc.reg_index == REG_PB_DATA && port_b_attached) begin
        res.port_b_drive       = acc.write_data;
        res.port_b_drive_mask  = acc.write_mask;
        res.port_b_drive_valid = 1'b1;
      end
    end
  end

  // Merged value of the addressed register
  always_comb begin
    unique case (acc.reg_index)
      REG_PA_CTRL:    wr_merged = merge(port_a_control, acc.write_data, acc.write_mask);
      REG_PA_DIR:     wr_merged = merge(port_a_direction, acc.write_data, acc.write_mask);
      REG_PA_DATA:    wr_merged = merge(port_a_latch, acc.write_data, acc.write_mask);
      REG_PB_CTRL:    wr_merged = merge(port_b_control, acc.write_data, acc.write_mask);
      REG_PB_DIR:     wr_merged = merge(port_b_direction, acc.write_data, acc.write_mask);
      REG_PB_DATA:    wr_merged = merge(port_b_latch, acc.write_data, acc.write_mask);
      REG_IRQ_ONE:    wr_merged = merge(irq_control_one, acc.write_data, acc.write_mask);
      // pending bits are write-one-to-clear regardless of mask
      REG_IRQ_TWO:    wr_merged = merge(irq_control_two, acc.write_data, acc.write_mask) &
                                  ~(acc.write_data & PENDING_BITS);
      REG_PERIPH_IRQ: wr_merged = merge(periph_irq_control, acc.write_data, acc.write_mask);
      REG_PERIPH_VEC: wr_merged = merge(periph_vector, acc.write_data, acc.write_mask);
      default:        wr_merged = merge(is_option ? select_option[sel_idx] :
                                        select_base[sel_idx], acc.write_data, acc.write_mask);
    endcase
  end

  // Configuration and register state
  always_ff @(posedge clk) begin
    if (rst) begin
      port_a_attached    <= 1'b1;
      port_b_attached    <= 1'b1;
      port_a_control     <= '0;
      port_a_direction   <= '0;
      port_a_latch       <= '0;
      port_b_control     <= '0;
      port_b_direction   <= '0;
      port_b_latch       <= '0;
      irq_control_one    <= '0;
      irq_control_two    <= '0;
      periph_irq_control <= '0;
      periph_vector      <= '0;
      for (int k = 0; k < NUM_CHIP_SELECTS; k++) begin
        select_base[k]   <= SELECT_BASE_RESET;
        select_option[k] <= SELECT_OPTION_RESET;
      end
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_PA_ATTACH) begin
          port_a_attached <= cfg_data;
        end
        if (cfg_index == CFG_PB_ATTACH) begin
          port_b_attached <= cfg_data;
        end
      end
      if (go && is_write) begin
        unique case (acc.reg_index)
          REG_PA_CTRL:    port_a_control     <= wr_merged;
          REG_PA_DIR:     port_a_direction   <= wr_merged;
          REG_PA_DATA:    port_a_latch       <= wr_merged;
          REG_PB_CTRL:    port_b_control     <= wr_merged;
          REG_PB_DIR:     port_b_direction   <= wr_merged;
          REG_PB_DATA:    port_b_latch       <= wr_merged;
          REG_IRQ_ONE:    irq_control_one    <= wr_merged;
          REG_IRQ_TWO:    irq_control_two    <= wr_merged;
          REG_PERIPH_IRQ: periph_irq_control <= wr_merged;
          REG_PERIPH_VEC: periph_vector      <= wr_merged;
          default: begin
            // unmapped indexes fall through with no effect
            if (is_select) begin
              if (is_option) begin
                select_option[sel_idx] <= wr_merged;
              end else begin
                select_base[sel_idx] <= wr_merged;
              end
            end
          end
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  // Pending bits written as one are clear afterwards
  a_irq_clear: assert property (@(posedge clk) disable iff (rst)
    go && is_write && acc.reg_index == REG_IRQ_TWO |=>
      (irq_control_two & $past(acc.write_data) & PENDING_BITS) == 16'h0000)
    else $error("pending bit survived a write-one-to-clear");

  // Drives only come from data-register writes
  a_drive_src: assert property (@(posedge clk) disable iff (rst)
    res.port_a_drive_valid || res.port_b_drive_valid |->
      is_write && (acc.reg_index == REG_PA_DATA || acc.reg_index == REG_PB_DATA))
    else $error("port drive from a non-data access");

  // Writes return zero read data
  a_write_rd: assert property (@(posedge clk) disable iff (rst)
    go && is_write |-> res.read_data == 16'h0000)
    else $error("write access returned read data");

  // Port state only moves on a consumed access
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !go |=> $stable(port_a_latch) && $stable(port_b_latch) && $stable(irq_control_two))
    else $error("register changed with no access");
`endif

endmodule
`default_nettype wire

// ----- hdl/gcs_out_reg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gcs_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module gcs_out_reg
  import gcs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res_in,
  output logic         room,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      res_out
);

  // Can load when empty or when the current result is taken this cycle
  assign room = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= load;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load && room) begin
      res_out <= res_in;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/gpio_chip_select_register_block.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpio_chip_select_register_block
// Bus-access register block for two GPIO ports, interrupt control words,
// a vector word and NUM_CHIP_SELECTS base/option chip-select pairs.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one read or write access; each yields
// exactly one result transfer. An access is captured in an input register,
// decoded against the register file and written to a result register, from
// which the result is presented. The block sustains one access per cycle as
// long as the output side takes results; with the output stalled it holds two
// accesses and then drops in_ready. Register state updates at the same edge
// the result is loaded, so a read always sees every earlier write. Port pin
// levels are sampled as part of the access. The attach configuration may only
// be changed while no access is in flight.
module gpio_chip_select_register_block
  import gcs_pkg::*;
#(
  parameter int NUM_CHIP_SELECTS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic                 cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 opcode,
  input  wire logic [4:0]           reg_index,
  input  wire logic [15:0]          write_data,
  input  wire logic [15:0]          write_mask,
  input  wire logic [7:0]           port_a_pins,
  input  wire logic [15:0]          port_b_pins,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [15:0]               read_data,
  output logic [7:0]                port_a_drive,
  output logic                      port_a_drive_valid,
  output logic [15:0]               port_b_drive,
  output logic [15:0]               port_b_drive_mask,
  output logic                      port_b_drive_valid
);

  access_t in_access;
  access_t held_access;
  logic    held_valid;
  logic    room;
  logic    go;
  result_t res;
  result_t res_out;

  // Pack the incoming access
  assign in_access = '{opcode:      opcode,
                       reg_index:   reg_index,
                       write_data:  write_data,
                       write_mask:  write_mask,
                       port_a_pins: port_a_pins,
                       port_b_pins: port_b_pins};

  // Access executes when held and the result register has room
  assign go = held_valid && room;

  gcs_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_access   (in_access),
    .take        (room),
    .held_valid  (held_valid),
    .held_access (held_access)
  );

  gcs_regfile #(
    .NUM_CHIP_SELECTS (NUM_CHIP_SELECTS)
  ) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .go        (go),
    .acc       (held_access),
    .res       (res)
  );

  gcs_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (held_valid),
    .res_in    (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  // Unpack the result
  assign read_data          = res_out.read_data;
  assign port_a_drive       = res_out.port_a_drive;
  assign port_a_drive_valid = res_out.port_a_drive_valid;
  assign port_b_drive       = res_out.port_b_drive;
  assign port_b_drive_mask  = res_out.port_b_drive_mask;
  assign port_b_drive_valid = res_out.port_b_drive_valid;

endmodule
`default_nettype wire
